@@ sv/vps_pkg.sv @@
package vps_pkg;

    localparam int MAX_BODIES_DEF = 64;
    localparam int SQRT_STEPS     = 32;
    localparam int DIV_STEPS      = 64;
    localparam int CNT_W          = 6;
    localparam logic [15:0] TIME_STEP_RESET = 16'd1092;

    typedef enum logic [2:0] {
        CMD_LOAD       = 3'd0,
        CMD_ACCELERATE = 3'd1,
        CMD_INTEGRATE  = 3'd2,
        CMD_POINT      = 3'd3,
        CMD_COLLIDE    = 3'd4,
        CMD_READ       = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_INACTIVE = 2'd1,
        STAT_ZERO     = 2'd2
    } status_t;

    typedef enum logic [0:0] {
        REG_TIME_STEP     = 1'b0,
        REG_ACTIVE_BODIES = 1'b1
    } reg_index_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_READ_B,
        S_DISPATCH,
        S_INT_D2,
        S_INT_X,
        S_INT_Y,
        S_INT_WR,
        S_COL_NEXT,
        S_PAIR,
        S_SQ_X,
        S_SQ_Y,
        S_SQ_SUM,
        S_SQRT,
        S_CHECK,
        S_PUSH_X,
        S_DIV_X,
        S_PUSH_Y,
        S_DIV_Y,
        S_APPLY,
        S_WRITE_B,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic [30:0]        radius;
        logic signed [31:0] acc_y;
        logic signed [31:0] acc_x;
        logic signed [31:0] prev_y;
        logic signed [31:0] prev_x;
        logic signed [31:0] cur_y;
        logic signed [31:0] cur_x;
    } entry_t;

    function automatic logic signed [65:0] sx66(input logic [31:0] v);
        return $signed({{34{v[31]}}, v});
    endfunction

    function automatic logic [31:0] sat32(input logic signed [65:0] v);
        logic [31:0] r;
        if (v > 66'sd2147483647)
            r = 32'h7FFF_FFFF;
        else if (v < -66'sd2147483648)
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic [31:0] mag32(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    // Product shifted down by 32 bits, rounded towards minus infinity for a negative factor.
    function automatic logic signed [65:0] scale_dt2(input logic [63:0] p, input logic neg);
        logic [64:0] r;
        logic [65:0] m;
        r = {1'b0, p} + 65'h0_FFFF_FFFF;
        m = neg ? {33'b0, r[64:32]} : {34'b0, p[63:32]};
        return neg ? -$signed(m) : $signed(m);
    endfunction

endpackage

@@ sv/verlet_particle_solver.sv @@
// Commands: load, read, accelerate, integrate, point constrain (the body may be pushed out) and collide
// (each other active body is checked and overlapping pairs are pushed apart). The square root (one root
// bit a cycle) and the restoring divider (one bit a cycle, twice per push) serve point and collide.
// One item is worked on at a time; the next can be taken in the cycle after the result is loaded.
// Reset clears the control state, the output valid and the active-body count and loads the default
// time step; the other registers and the body entries are undefined until loaded.
module verlet_particle_solver #(
    parameter int MAX_BODIES = vps_pkg::MAX_BODIES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // body_index[5:0], value_x[37:6], value_y[69:38], body_radius[100:70], zero padding
    input  logic [103:0] s_axis_tdata,
    // cmd[2:0]
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // result_index[5:0], pos_x[37:6], pos_y[69:38], status[71:70]
    output logic [71:0]  m_axis_tdata,
    input  logic         cfg_we,
    input  logic [0:0]   cfg_index,
    input  logic [15:0]  cfg_data
);
    import vps_pkg::*;

    localparam int AW = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
    localparam int CW = $clog2(MAX_BODIES + 1);
    localparam int LW = (CW > 7) ? CW : 7;

    state_t        state_reg, state_next;
    logic [15:0]   time_step_reg;
    logic [6:0]    active_reg;
    logic          m_valid_reg;
    logic [71:0]   m_data_reg;

    entry_t        body_mem [MAX_BODIES];
    entry_t        rd_data_reg;
    entry_t        mem_wdata;
    logic [AW-1:0] mem_addr;
    logic          mem_we;

    cmd_t          cmd_reg;
    logic [5:0]    b_reg;
    logic [31:0]   vx_reg, vy_reg;
    status_t       status_reg;
    entry_t        body_reg, oth_reg;
    logic [LW-1:0] i_reg;
    logic [31:0]   ax_reg, ay_reg;
    logic [31:0]   want_reg, k_reg;
    logic [33:0]   dvs_reg;
    logic [63:0]   sum_reg, sq_reg;
    logic [63:0]   rt_n_reg;
    logic [31:0]   rt_root_reg;
    logic [33:0]   rt_rem_reg;
    logic [63:0]   dq_reg, qx_reg;
    logic [33:0]   dv_rem_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic          in_acc;
    logic          in_bad;
    cmd_t          in_cmd;
    logic [5:0]    in_b;
    logic [LW-1:0] act;
    logic [31:0]   mul_a, mul_b;
    logic [63:0]   prod;
    logic [35:0]   rt_sh, rt_trial;
    logic [34:0]   dv_sh;
    logic          dv_bit;
    logic [33:0]   dv_rem_nx;
    logic signed [65:0] qx66, qy66;
    logic [31:0]   nbx, nby, nix, niy;
    logic          is_col;
    entry_t        acc_body;

    assign in_cmd = cmd_t'(s_axis_tuser);
    assign in_b   = s_axis_tdata[5:0];
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign act    = (LW'(active_reg) > LW'(MAX_BODIES)) ? LW'(MAX_BODIES) : LW'(active_reg);
    assign in_bad = (int'(in_b) >= MAX_BODIES) || ((in_cmd != CMD_LOAD) && (LW'(in_b) >= act));
    assign is_col = (cmd_reg == CMD_COLLIDE);

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    assign prod = mul_a * mul_b;

    assign rt_sh    = {rt_rem_reg, rt_n_reg[63:62]};
    assign rt_trial = {2'b00, rt_root_reg, 2'b01};

    assign dv_sh     = {dv_rem_reg, dq_reg[63]};
    assign dv_bit    = (dv_sh >= {1'b0, dvs_reg});
    assign dv_rem_nx = dv_bit ? 34'(dv_sh - {1'b0, dvs_reg}) : dv_sh[33:0];

    assign qx66 = ax_reg[31] ? -$signed({2'b00, qx_reg}) : $signed({2'b00, qx_reg});
    assign qy66 = ay_reg[31] ? -$signed({2'b00, dq_reg}) : $signed({2'b00, dq_reg});
    assign nbx  = is_col ? sat32(sx66(body_reg.cur_x) + qx66) : sat32(sx66(vx_reg) + qx66);
    assign nby  = is_col ? sat32(sx66(body_reg.cur_y) + qy66) : sat32(sx66(vy_reg) + qy66);
    assign nix  = sat32(sx66(oth_reg.cur_x) - qx66);
    assign niy  = sat32(sx66(oth_reg.cur_y) - qy66);

    always_comb
    begin
        acc_body       = rd_data_reg;
        acc_body.acc_x = sat32(sx66(rd_data_reg.acc_x) + sx66(vx_reg));
        acc_body.acc_y = sat32(sx66(rd_data_reg.acc_y) + sx66(vy_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        mem_we     = 1'b0;
        mem_addr   = AW'(b_reg);
        mem_wdata  = body_reg;
        mul_a      = mag32(ax_reg);
        mul_b      = mag32(ax_reg);
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (in_bad)
                        state_next = S_RESULT;
                    else if (in_cmd == CMD_LOAD)
                        state_next = S_WRITE_B;
                    else
                        state_next = S_READ_B;
                end
            end
            S_READ_B:
            begin
                state_next = S_DISPATCH;
            end
            S_DISPATCH:
            begin
                unique case (cmd_reg)
                    CMD_ACCELERATE: state_next = S_WRITE_B;
                    CMD_INTEGRATE:  state_next = S_INT_D2;
                    CMD_POINT:      state_next = S_SQ_X;
                    CMD_COLLIDE:    state_next = S_COL_NEXT;
                    default:        state_next = S_RESULT;
                endcase
            end
            S_INT_D2:
            begin
                mul_a      = {16'b0, time_step_reg};
                mul_b      = {16'b0, time_step_reg};
                state_next = S_INT_X;
            end
            S_INT_X:
            begin
                mul_a      = mag32(body_reg.acc_x);
                mul_b      = sum_reg[31:0];
                state_next = S_INT_Y;
            end
            S_INT_Y:
            begin
                mul_a      = mag32(body_reg.acc_y);
                mul_b      = sum_reg[31:0];
                state_next = S_INT_WR;
            end
            S_INT_WR:
            begin
                state_next = S_WRITE_B;
            end
            S_COL_NEXT:
            begin
                mem_addr = i_reg[AW-1:0];
                if (i_reg >= act)
                    state_next = S_WRITE_B;
                else if (i_reg != LW'(b_reg))
                    state_next = S_PAIR;
            end
            S_PAIR:
            begin
                state_next = S_SQ_X;
            end
            S_SQ_X:
            begin
                state_next = S_SQ_Y;
            end
            S_SQ_Y:
            begin
                mul_a      = mag32(ay_reg);
                mul_b      = mag32(ay_reg);
                state_next = S_SQ_SUM;
            end
            S_SQ_SUM:
            begin
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                if (cnt_reg == CNT_W'(SQRT_STEPS - 1))
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if ((rt_root_reg < want_reg) && (rt_root_reg != 32'd0))
                    state_next = S_PUSH_X;
                else if (is_col)
                    state_next = S_COL_NEXT;
                else
                    state_next = S_RESULT;
            end
            S_PUSH_X:
            begin
                mul_b      = k_reg;
                state_next = S_DIV_X;
            end
            S_DIV_X:
            begin
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    state_next = S_PUSH_Y;
            end
            S_PUSH_Y:
            begin
                mul_a      = mag32(ay_reg);
                mul_b      = k_reg;
                state_next = S_DIV_Y;
            end
            S_DIV_Y:
            begin
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    state_next = S_APPLY;
            end
            S_APPLY:
            begin
                if (is_col)
                begin
                    mem_we          = 1'b1;
                    mem_addr        = i_reg[AW-1:0];
                    mem_wdata       = oth_reg;
                    mem_wdata.cur_x = nix;
                    mem_wdata.cur_y = niy;
                    state_next      = S_COL_NEXT;
                end
                else
                begin
                    state_next = S_WRITE_B;
                end
            end
            S_WRITE_B:
            begin
                mem_we     = 1'b1;
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (!m_valid_reg || m_axis_tready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            body_mem[mem_addr] <= mem_wdata;
        rd_data_reg <= body_mem[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg <= TIME_STEP_RESET;
            active_reg    <= 7'd0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == REG_TIME_STEP))
                time_step_reg <= cfg_data;
            if (cfg_we && (cfg_index == REG_ACTIVE_BODIES))
                active_reg <= cfg_data[6:0];
            if (state_reg == S_RESULT && (!m_valid_reg || m_axis_tready))
                m_valid_reg <= 1'b1;
            else if (m_axis_tready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    cmd_reg         <= in_cmd;
                    b_reg           <= in_b;
                    vx_reg          <= s_axis_tdata[37:6];
                    vy_reg          <= s_axis_tdata[69:38];
                    status_reg      <= in_bad ? STAT_INACTIVE : STAT_OK;
                    body_reg.cur_x  <= s_axis_tdata[37:6];
                    body_reg.cur_y  <= s_axis_tdata[69:38];
                    body_reg.prev_x <= s_axis_tdata[37:6];
                    body_reg.prev_y <= s_axis_tdata[69:38];
                    body_reg.acc_x  <= 32'sd0;
                    body_reg.acc_y  <= 32'sd0;
                    body_reg.radius <= s_axis_tdata[100:70];
                end
            end
            S_DISPATCH:
            begin
                body_reg <= (cmd_reg == CMD_ACCELERATE) ? acc_body : rd_data_reg;
                i_reg    <= '0;
                ax_reg   <= sat32(sx66(rd_data_reg.cur_x) - sx66(vx_reg));
                ay_reg   <= sat32(sx66(rd_data_reg.cur_y) - sx66(vy_reg));
                want_reg <= {1'b0, rd_data_reg.radius};
            end
            S_INT_D2:
            begin
                sum_reg <= prod;
            end
            S_INT_X:
            begin
                dq_reg <= prod;
            end
            S_INT_Y:
            begin
                sq_reg          <= prod;
                body_reg.prev_x <= body_reg.cur_x;
                body_reg.cur_x  <= sat32((sx66(body_reg.cur_x) <<< 1) - sx66(body_reg.prev_x)
                                         + scale_dt2(dq_reg, body_reg.acc_x[31]));
                body_reg.acc_x  <= 32'sd0;
            end
            S_INT_WR:
            begin
                body_reg.prev_y <= body_reg.cur_y;
                body_reg.cur_y  <= sat32((sx66(body_reg.cur_y) <<< 1) - sx66(body_reg.prev_y)
                                         + scale_dt2(sq_reg, body_reg.acc_y[31]));
                body_reg.acc_y  <= 32'sd0;
            end
            S_COL_NEXT:
            begin
                if ((i_reg < act) && (i_reg == LW'(b_reg)))
                    i_reg <= i_reg + LW'(1);
            end
            S_PAIR:
            begin
                oth_reg  <= rd_data_reg;
                ax_reg   <= sat32(sx66(body_reg.cur_x) - sx66(rd_data_reg.cur_x));
                ay_reg   <= sat32(sx66(body_reg.cur_y) - sx66(rd_data_reg.cur_y));
                want_reg <= {1'b0, body_reg.radius} + {1'b0, rd_data_reg.radius};
            end
            S_SQ_X:
            begin
                sum_reg <= prod;
            end
            S_SQ_Y:
            begin
                sq_reg <= prod;
            end
            S_SQ_SUM:
            begin
                rt_n_reg    <= sum_reg + sq_reg;
                rt_root_reg <= 32'd0;
                rt_rem_reg  <= 34'd0;
                cnt_reg     <= '0;
            end
            S_SQRT:
            begin
                rt_n_reg <= {rt_n_reg[61:0], 2'b00};
                cnt_reg  <= cnt_reg + CNT_W'(1);
                if (rt_sh >= rt_trial)
                begin
                    rt_rem_reg  <= 34'(rt_sh - rt_trial);
                    rt_root_reg <= {rt_root_reg[30:0], 1'b1};
                end
                else
                begin
                    rt_rem_reg  <= rt_sh[33:0];
                    rt_root_reg <= {rt_root_reg[30:0], 1'b0};
                end
            end
            S_CHECK:
            begin
                if (rt_root_reg < want_reg)
                begin
                    if (rt_root_reg == 32'd0)
                        status_reg <= STAT_ZERO;
                    k_reg   <= is_col ? (want_reg - rt_root_reg) : want_reg;
                    dvs_reg <= is_col ? {1'b0, rt_root_reg, 1'b0} : {2'b00, rt_root_reg};
                end
                if (is_col && !((rt_root_reg < want_reg) && (rt_root_reg != 32'd0)))
                    i_reg <= i_reg + LW'(1);
            end
            S_PUSH_X:
            begin
                dq_reg     <= prod;
                dv_rem_reg <= 34'd0;
                cnt_reg    <= '0;
            end
            S_DIV_X, S_DIV_Y:
            begin
                dq_reg     <= {dq_reg[62:0], dv_bit};
                dv_rem_reg <= dv_rem_nx;
                cnt_reg    <= cnt_reg + CNT_W'(1);
            end
            S_PUSH_Y:
            begin
                qx_reg     <= dq_reg;
                dq_reg     <= prod;
                dv_rem_reg <= 34'd0;
                cnt_reg    <= '0;
            end
            S_APPLY:
            begin
                body_reg.cur_x <= nbx;
                body_reg.cur_y <= nby;
                if (is_col)
                    i_reg <= i_reg + LW'(1);
            end
            S_RESULT:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_data_reg[5:0]   <= b_reg;
                    m_data_reg[37:6]  <= (status_reg == STAT_INACTIVE) ? 32'd0 : body_reg.cur_x;
                    m_data_reg[69:38] <= (status_reg == STAT_INACTIVE) ? 32'd0 : body_reg.cur_y;
                    m_data_reg[71:70] <= status_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

`ifndef SYNTHESIS
    a_no_self_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_APPLY && cmd_reg == CMD_COLLIDE) |-> (i_reg != LW'(b_reg)))
        else $error("collide pair write hits the body being walked");

    a_push_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PUSH_X) |-> (rt_root_reg != 32'd0 && rt_root_reg < want_reg))
        else $error("push started without a non-zero overlapping distance");

    a_pair_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PAIR) |-> (i_reg < act && cmd_reg == CMD_COLLIDE))
        else $error("pair visited outside the active range");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg != S_IDLE))
        else $error("accepted item did not start work");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESULT && m_axis_tvalid && !m_axis_tready) |=> (state_reg == S_RESULT))
        else $error("result dropped while output register is full");
`endif

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
    import vps_pkg::*;

    localparam int BODIES = 64;
    localparam logic [2:0] CMD_SPARE_LO = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;
    localparam int STALL_LIMIT = 100000;

    typedef struct {
        logic [5:0]  idx;
        logic [31:0] x;
        logic [31:0] y;
        logic [1:0]  status;
    } body_result_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata = '0;
    logic [2:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [71:0]  m_axis_tdata;
    logic         cfg_we = 1'b0;
    logic [0:0]   cfg_index = '0;
    logic [15:0]  cfg_data = '0;

    // Predicted body table and registers.
    int          cur_x[BODIES], cur_y[BODIES], prev_x[BODIES], prev_y[BODIES];
    int          acc_x[BODIES], acc_y[BODIES];
    int unsigned rad_tab[BODIES];
    bit          loaded[BODIES];
    logic [15:0] dt_reg;
    logic [6:0]  active_reg;

    body_result_t pending_results[$];
    int errors = 0;
    int results_seen = 0;
    int cmd_count[8];
    int zero_pushes = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int quiet_cycles = 0;

    verlet_particle_solver dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    function automatic int sat32(input longint v);
        if (v > 64'sd2147483647)
            return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'h8000_0000;
        return int'(v);
    endfunction

    function automatic longint unsigned magnitude(input longint v);
        return v < 0 ? longint'(-v) : v;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned span(input longint ax, input longint ay);
        longint unsigned mx, my;
        mx = magnitude(ax);
        my = magnitude(ay);
        return int_sqrt(mx * mx + my * my);
    endfunction

    function automatic longint scaled_accel(input int a, input longint unsigned d2);
        longint unsigned m;
        m = magnitude(a) * d2;
        if (a >= 0)
            return longint'(m >> 32);
        return -longint'((m + 64'hFFFF_FFFF) >> 32);
    endfunction

    function automatic longint push_share(input longint ax, input longint unsigned k,
                                          input longint unsigned d);
        longint unsigned q;
        q = (magnitude(ax) * k) / d;
        return ax < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic body_result_t solve_command(input logic [2:0] cmd,
                                                   input logic [5:0] b,
                                                   input int vx, input int vy,
                                                   input logic [30:0] rad);
        body_result_t r;
        int eff;
        longint ax, ay, sx, sy, nx, ny;
        longint unsigned d, want, d2;
        eff = active_reg > BODIES ? BODIES : active_reg;
        r.idx = b;
        r.status = STAT_OK;
        if (cmd != CMD_LOAD && b >= eff)
        begin
            r.x = '0;
            r.y = '0;
            r.status = STAT_INACTIVE;
            return r;
        end
        case (cmd)
            CMD_LOAD:
            begin
                cur_x[b] = vx;
                prev_x[b] = vx;
                cur_y[b] = vy;
                prev_y[b] = vy;
                acc_x[b] = 0;
                acc_y[b] = 0;
                rad_tab[b] = {1'b0, rad};
                loaded[b] = 1'b1;
            end
            CMD_ACCELERATE:
            begin
                acc_x[b] = sat32(longint'(acc_x[b]) + vx);
                acc_y[b] = sat32(longint'(acc_y[b]) + vy);
            end
            CMD_INTEGRATE:
            begin
                d2 = longint'(dt_reg) * longint'(dt_reg);
                nx = 2 * longint'(cur_x[b]) - prev_x[b] + scaled_accel(acc_x[b], d2);
                ny = 2 * longint'(cur_y[b]) - prev_y[b] + scaled_accel(acc_y[b], d2);
                acc_x[b] = 0;
                acc_y[b] = 0;
                prev_x[b] = cur_x[b];
                prev_y[b] = cur_y[b];
                cur_x[b] = sat32(nx);
                cur_y[b] = sat32(ny);
            end
            CMD_POINT:
            begin
                ax = sat32(longint'(cur_x[b]) - vx);
                ay = sat32(longint'(cur_y[b]) - vy);
                d = span(ax, ay);
                if (d < rad_tab[b])
                begin
                    if (d == 0)
                        r.status = STAT_ZERO;
                    else
                    begin
                        cur_x[b] = sat32(vx + push_share(ax, rad_tab[b], d));
                        cur_y[b] = sat32(vy + push_share(ay, rad_tab[b], d));
                    end
                end
            end
            CMD_COLLIDE:
            begin
                for (int i = 0; i < eff; i++)
                begin
                    if (i == b)
                        continue;
                    ax = sat32(longint'(cur_x[b]) - cur_x[i]);
                    ay = sat32(longint'(cur_y[b]) - cur_y[i]);
                    d = span(ax, ay);
                    want = longint'(rad_tab[b]) + rad_tab[i];
                    if (d >= want)
                        continue;
                    if (d == 0)
                    begin
                        r.status = STAT_ZERO;
                        continue;
                    end
                    sx = push_share(ax, want - d, 2 * d);
                    sy = push_share(ay, want - d, 2 * d);
                    cur_x[b] = sat32(longint'(cur_x[b]) + sx);
                    cur_y[b] = sat32(longint'(cur_y[b]) + sy);
                    cur_x[i] = sat32(longint'(cur_x[i]) - sx);
                    cur_y[i] = sat32(longint'(cur_y[i]) - sy);
                end
            end
            default:
            begin
            end
        endcase
        r.x = cur_x[b];
        r.y = cur_y[b];
        return r;
    endfunction

    task automatic send_command(input logic [2:0] cmd, input logic [5:0] b,
                                input int vx, input int vy, input logic [30:0] rad);
        body_result_t r;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= {3'b0, rad, vy, vx, b};
        do
            @(posedge clk);
        while (!s_axis_tready);
        r = solve_command(cmd, b, vx, vy, rad);
        if (r.status == STAT_ZERO)
            zero_pushes++;
        cmd_count[cmd]++;
        pending_results.push_back(r);
    endtask

    task automatic wait_all_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_register(input reg_index_t idx, input logic [15:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_TIME_STEP)
            dt_reg = value;
        else
            active_reg = value[6:0];
        @(posedge clk);
    endtask

    function automatic int near_coord();
        return int'($urandom_range(0, 8 << 16)) - (4 << 16);
    endfunction

    function automatic int pick_coord();
        return ($urandom_range(7) == 0) ? int'($urandom) : near_coord();
    endfunction

    function automatic logic [30:0] pick_radius();
        logic [31:0] w;
        w = $urandom;
        return ($urandom_range(9) == 0) ? w[30:0] : 31'($urandom_range(1 << 15, 3 << 16));
    endfunction

    // Commands touching an unloaded active body become a load of the lowest such body.
    task automatic send_random_command();
        logic [2:0] cmd;
        logic [5:0] b;
        int eff;
        int missing;
        eff = active_reg > BODIES ? BODIES : active_reg;
        cmd = 3'($urandom_range(7));
        if (cmd > CMD_READ && $urandom_range(3) != 0)
            cmd = CMD_COLLIDE;
        b = (eff > 0 && $urandom_range(9) != 0) ? 6'($urandom_range(eff - 1))
                                                : 6'($urandom);
        missing = -1;
        if (cmd != CMD_LOAD && b < eff && !loaded[b])
            missing = int'(b);
        if (cmd == CMD_COLLIDE && b < eff)
            for (int i = eff - 1; i >= 0; i--)
                if (!loaded[i])
                    missing = i;
        if (missing >= 0)
        begin
            cmd = CMD_LOAD;
            b = 6'(missing);
        end
        send_command(cmd, b, pick_coord(), pick_coord(), pick_radius());
    endtask

    task automatic test_directed();
        write_register(REG_TIME_STEP, 16'hFFFF);
        write_register(REG_ACTIVE_BODIES, 16'd4);
        send_command(CMD_LOAD, 6'd0, 32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF);
        send_command(CMD_LOAD, 6'd1, 32'h0001_0000, 32'h0002_0000, 31'h0001_8000);
        send_command(CMD_LOAD, 6'd2, 32'h0001_0000, 32'h0002_0000, 31'h0000_8000);
        send_command(CMD_LOAD, 6'd3, 32'h0001_8000, 32'h0002_4000, 31'h0001_0000);
        send_command(CMD_LOAD, 6'd63, 32'h8000_0000, 32'h7FFF_FFFF, 31'h0);
        send_command(CMD_READ, 6'd63, 0, 0, 31'd0);
        send_command(CMD_READ, 6'd0, 0, 0, 31'd0);
        send_command(CMD_ACCELERATE, 6'd0, 32'h7FFF_FFFF, 32'h8000_0000, 31'd0);
        send_command(CMD_ACCELERATE, 6'd0, 32'h7FFF_FFFF, 32'h8000_0000, 31'd0);
        send_command(CMD_INTEGRATE, 6'd0, 0, 0, 31'd0);
        send_command(CMD_ACCELERATE, 6'd3, 32'hFFFF_FFFF, 32'h0000_0001, 31'd0);
        send_command(CMD_INTEGRATE, 6'd3, 0, 0, 31'd0);
        send_command(CMD_POINT, 6'd1, 32'h0001_0000, 32'h0002_0000, 31'd0);
        send_command(CMD_POINT, 6'd2, 32'h0001_4000, 32'h0002_0000, 31'd0);
        send_command(CMD_POINT, 6'd0, 32'h8000_0000, 32'h7FFF_FFFF, 31'd0);
        send_command(CMD_COLLIDE, 6'd1, 0, 0, 31'd0);
        send_command(CMD_COLLIDE, 6'd3, 0, 0, 31'd0);
        send_command(CMD_SPARE_LO, 6'd2, 0, 0, 31'd0);
        send_command(CMD_SPARE_HI, 6'd3, 0, 0, 31'd0);
        send_command(CMD_INTEGRATE, 6'd5, 0, 0, 31'd0);
        wait_all_results();
        write_register(REG_TIME_STEP, 16'h0000);
        write_register(REG_ACTIVE_BODIES, 16'd0);
        send_command(CMD_READ, 6'd0, 0, 0, 31'd0);
        send_command(CMD_LOAD, 6'd7, 32'h0000_0001, 32'hFFFF_FFFF, 31'h1);
        wait_all_results();
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                     input logic [15:0] dt, input logic [6:0] active,
                                     input int count);
        write_register(REG_TIME_STEP, dt);
        write_register(REG_ACTIVE_BODIES, {9'd0, active});
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < count; n++)
        begin
            if (n == count / 2)
                wait_all_results();
            send_random_command();
        end
        wait_all_results();
    endtask

    always @(posedge clk)
    begin
        body_result_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("result with nothing expected: %h", m_axis_tdata);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tdata[5:0] !== want.idx)
                begin
                    $error("result_index: expected %0d, got %0d", want.idx, m_axis_tdata[5:0]);
                    errors++;
                end
                if (m_axis_tdata[37:6] !== want.x)
                begin
                    $error("pos_x: expected %h, got %h", want.x, m_axis_tdata[37:6]);
                    errors++;
                end
                if (m_axis_tdata[69:38] !== want.y)
                begin
                    $error("pos_y: expected %h, got %h", want.y, m_axis_tdata[69:38]);
                    errors++;
                end
                if (m_axis_tdata[71:70] !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, m_axis_tdata[71:70]);
                    errors++;
                end
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial
    begin
        dt_reg = TIME_STEP_RESET;
        active_reg = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_phase(0, 0, 16'd1092, 7'd8, 100);
        test_random_phase(69, 0, 16'hFFFF, 7'd2, 90);
        test_random_phase(0, 69, 16'h8001, 7'd64, 90);
        test_random_phase(14, 14, 16'($urandom), 7'd127, 90);
        $display("Ran %0d commands (load %0d, collide %0d, point %0d) with %0d results checked,",
                 cmd_count.sum(), cmd_count[CMD_LOAD], cmd_count[CMD_COLLIDE],
                 cmd_count[CMD_POINT], results_seen);
        $display("over five register settings and four idling phases; %0d pushes skipped.",
                 zero_pushes);
        if (errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

@@ verlet_particle_solver.f @@
sv/vps_pkg.sv
sv/verlet_particle_solver.sv
tb/testbench.sv
